FILE: hdl/ksd_pkg.sv
package ksd_pkg;

  localparam int CMD_QUEUE_DEPTH = 8;
  localparam int QPTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(CMD_QUEUE_DEPTH + 1);
  localparam int QSUM_W = QCNT_W + 1;

  localparam int LED_W = 3;

  // Bytes exchanged with the keyboard
  localparam logic [7:0] LED_CMD   = 8'hED;
  localparam logic [7:0] KB_ACK    = 8'hFA;
  localparam logic [7:0] KB_RESEND = 8'hFE;

  // Set-1 make and break codes
  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
  localparam logic [7:0] SC_LCTRL      = 8'h1D;
  localparam logic [7:0] SC_LCTRL_BRK  = 8'h9D;
  localparam logic [7:0] SC_CAPS       = 8'h3A;
  localparam logic [7:0] SC_NUM        = 8'h45;
  localparam logic [7:0] SC_SCROLL     = 8'h46;
  localparam logic [7:0] SC_BACKSPACE  = 8'h0E;
  localparam logic [7:0] SC_ENTER      = 8'h1C;
  localparam logic [7:0] SC_TAB        = 8'h0F;
  localparam logic [7:0] SC_F11        = 8'h57;
  localparam logic [7:0] SC_C          = 8'h2E;

  localparam logic [LED_W-1:0] LED_CAPS   = 3'b100;
  localparam logic [LED_W-1:0] LED_NUM    = 3'b010;
  localparam logic [LED_W-1:0] LED_SCROLL = 3'b001;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    logic       backspace_key;
    logic       enter_key;
    logic       tab_key;
    logic       break_request;
    logic       f11_key;
  } key_out_t;

  typedef struct packed {
    logic push_led;
    logic ack;
    logic resend;
  } q_ctl_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       overflow;
  } tx_out_t;

  // Entries that are the same in both tables
  function automatic logic [6:0] common_map(input logic [6:0] code);
    logic [6:0] ch;
    ch = 7'h00;
    case (code)
      7'h10: ch = 7'h51;
      7'h11: ch = 7'h57;
      7'h12: ch = 7'h45;
      7'h13: ch = 7'h52;
      7'h14: ch = 7'h54;
      7'h15: ch = 7'h59;
      7'h16: ch = 7'h55;
      7'h17: ch = 7'h49;
      7'h18: ch = 7'h4F;
      7'h19: ch = 7'h50;
      7'h1E: ch = 7'h41;
      7'h1F: ch = 7'h53;
      7'h20: ch = 7'h44;
      7'h21: ch = 7'h46;
      7'h22: ch = 7'h47;
      7'h23: ch = 7'h48;
      7'h24: ch = 7'h4A;
      7'h25: ch = 7'h4B;
      7'h26: ch = 7'h4C;
      7'h2C: ch = 7'h5A;
      7'h2D: ch = 7'h58;
      7'h2E: ch = 7'h43;
      7'h2F: ch = 7'h56;
      7'h30: ch = 7'h42;
      7'h31: ch = 7'h4E;
      7'h32: ch = 7'h4D;
      7'h37: ch = 7'h2A;
      7'h39: ch = 7'h20;
      7'h47: ch = 7'h37;
      7'h48: ch = 7'h38;
      7'h49: ch = 7'h39;
      7'h4A: ch = 7'h2D;
      7'h4B: ch = 7'h34;
      7'h4C: ch = 7'h35;
      7'h4D: ch = 7'h36;
      7'h4E: ch = 7'h2B;
      7'h4F: ch = 7'h31;
      7'h50: ch = 7'h32;
      7'h51: ch = 7'h33;
      7'h52: ch = 7'h30;
      7'h53: ch = 7'h2E;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] plain_map(input logic [6:0] code);
    logic [6:0] ch;
    ch = common_map(code);
    case (code)
      7'h02: ch = 7'h31;
      7'h03: ch = 7'h32;
      7'h04: ch = 7'h33;
      7'h05: ch = 7'h34;
      7'h06: ch = 7'h35;
      7'h07: ch = 7'h36;
      7'h08: ch = 7'h37;
      7'h09: ch = 7'h38;
      7'h0A: ch = 7'h39;
      7'h0B: ch = 7'h30;
      7'h0C: ch = 7'h2D;
      7'h0D: ch = 7'h5E;
      7'h1A: ch = 7'h40;
      7'h1B: ch = 7'h5B;
      7'h27: ch = 7'h3B;
      7'h28: ch = 7'h3A;
      7'h2B: ch = 7'h5D;
      7'h33: ch = 7'h2C;
      7'h34: ch = 7'h2E;
      7'h35: ch = 7'h2F;
      default: ch = ch;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] shift_map(input logic [6:0] code);
    logic [6:0] ch;
    ch = common_map(code);
    case (code)
      7'h02: ch = 7'h21;
      7'h03: ch = 7'h22;
      7'h04: ch = 7'h23;
      7'h05: ch = 7'h24;
      7'h06: ch = 7'h25;
      7'h07: ch = 7'h26;
      7'h08: ch = 7'h27;
      7'h09: ch = 7'h28;
      7'h0A: ch = 7'h29;
      7'h0B: ch = 7'h7E;
      7'h0C: ch = 7'h3D;
      7'h0D: ch = 7'h7E;
      7'h1A: ch = 7'h60;
      7'h1B: ch = 7'h7B;
      7'h27: ch = 7'h2B;
      7'h28: ch = 7'h2A;
      7'h2B: ch = 7'h7D;
      7'h33: ch = 7'h3C;
      7'h34: ch = 7'h3E;
      7'h35: ch = 7'h3F;
      7'h73: ch = 7'h5F;
      7'h7D: ch = 7'h7C;
      default: ch = ch;
    endcase
    return ch;
  endfunction

endpackage

FILE: hdl/ksd_key_decode.sv
module ksd_key_decode
  import ksd_pkg::*;
(
  input  logic             command,
  input  logic [7:0]       scan_byte,
  input  logic [1:0]       shift_held,
  input  logic             ctrl_held,
  input  logic [LED_W-1:0] lock_leds,
  input  logic [LED_W-1:0] boot_leds,
  output key_out_t         keys,
  output q_ctl_t           q_ctl,
  output logic [1:0]       shift_held_next,
  output logic             ctrl_held_next,
  output logic [LED_W-1:0] lock_leds_next
);

  logic [6:0] ch;
  logic       shifted;

  assign shifted = |shift_held;

  always_comb begin
    ch              = 7'h00;
    keys            = '0;
    q_ctl           = '0;
    shift_held_next = shift_held;
    ctrl_held_next  = ctrl_held;
    lock_leds_next  = lock_leds;

    if (command) begin
      lock_leds_next = boot_leds;
      q_ctl.push_led = 1'b1;
    end else begin
      if (!scan_byte[7]) begin
        ch = shifted ? shift_map(scan_byte[6:0]) : plain_map(scan_byte[6:0]);
        // letters come out lowercase unless caps lock and shift disagree
        if ((ch inside {[7'h41:7'h5A]}) && (lock_leds[2] == shifted)) begin
          ch = ch + 7'h20;
        end
      end
      keys.char_valid    = (ch != 7'h00);
      keys.char_code     = ch;
      keys.backspace_key = (scan_byte == SC_BACKSPACE);
      keys.enter_key     = (scan_byte == SC_ENTER);
      keys.tab_key       = (scan_byte == SC_TAB);
      keys.f11_key       = (scan_byte == SC_F11);
      keys.break_request = (scan_byte == SC_C) && ctrl_held;

      case (scan_byte)
        SC_LSHIFT:     shift_held_next = shift_held | 2'b01;
        SC_LSHIFT_BRK: shift_held_next = shift_held & 2'b10;
        SC_RSHIFT:     shift_held_next = shift_held | 2'b10;
        SC_RSHIFT_BRK: shift_held_next = shift_held & 2'b01;
        SC_LCTRL:      ctrl_held_next  = 1'b1;
        SC_LCTRL_BRK:  ctrl_held_next  = 1'b0;
        SC_CAPS: begin
          lock_leds_next = lock_leds ^ LED_CAPS;
          q_ctl.push_led = 1'b1;
        end
        SC_NUM: begin
          lock_leds_next = lock_leds ^ LED_NUM;
          q_ctl.push_led = 1'b1;
        end
        SC_SCROLL: begin
          lock_leds_next = lock_leds ^ LED_SCROLL;
          q_ctl.push_led = 1'b1;
        end
        KB_ACK:    q_ctl.ack    = 1'b1;
        KB_RESEND: q_ctl.resend = 1'b1;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hdl/ksd_cmd_queue.sv
module ksd_cmd_queue
  import ksd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  q_ctl_t           q_ctl,
  input  logic [LED_W-1:0] led_byte,
  output tx_out_t          tx
);

  logic [7:0]        queue_mem [CMD_QUEUE_DEPTH];
  logic [QPTR_W-1:0] queue_head, queue_head_next;
  logic [QCNT_W-1:0] queue_count, queue_count_next;
  logic              awaiting_ack, awaiting_ack_next;
  logic [7:0]        inflight_byte, inflight_byte_next;

  logic              ok1, ok2, pop, awaiting_mid, resend_tx;
  logic [QCNT_W-1:0] cnt1, cnt2;
  logic [QSUM_W-1:0] sum1, sum2;
  logic [QPTR_W-1:0] pos1, pos2;
  logic [7:0]        pop_byte;

  always_comb begin
    ok1  = q_ctl.push_led && (queue_count < QCNT_W'(CMD_QUEUE_DEPTH));
    cnt1 = queue_count + QCNT_W'(ok1);
    ok2  = q_ctl.push_led && (cnt1 < QCNT_W'(CMD_QUEUE_DEPTH));
    cnt2 = cnt1 + QCNT_W'(ok2);

    sum1 = QSUM_W'(queue_head) + QSUM_W'(queue_count);
    if (sum1 >= QSUM_W'(CMD_QUEUE_DEPTH)) sum1 = sum1 - QSUM_W'(CMD_QUEUE_DEPTH);
    sum2 = QSUM_W'(queue_head) + QSUM_W'(cnt1);
    if (sum2 >= QSUM_W'(CMD_QUEUE_DEPTH)) sum2 = sum2 - QSUM_W'(CMD_QUEUE_DEPTH);
    pos1 = sum1[QPTR_W-1:0];
    pos2 = sum2[QPTR_W-1:0];

    awaiting_mid = awaiting_ack && !q_ctl.ack;
    resend_tx    = q_ctl.resend && awaiting_ack;
    pop          = !awaiting_mid && (cnt2 != '0);
    // an empty queue can only pop the command byte pushed in this beat
    pop_byte     = (queue_count == '0) ? LED_CMD : queue_mem[queue_head];

    tx.overflow = q_ctl.push_led && !(ok1 && ok2);
    tx.tx_valid = pop || resend_tx;
    tx.tx_byte  = pop ? pop_byte : (resend_tx ? inflight_byte : 8'h00);

    queue_head_next    = queue_head;
    if (pop) begin
      queue_head_next = (queue_head == QPTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0
                                                                      : queue_head + QPTR_W'(1);
    end
    queue_count_next   = cnt2 - QCNT_W'(pop);
    awaiting_ack_next  = pop ? 1'b1 : awaiting_mid;
    inflight_byte_next = pop ? pop_byte : inflight_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_head    <= '0;
      queue_count   <= '0;
      awaiting_ack  <= 1'b0;
      inflight_byte <= 8'h00;
    end else if (step) begin
      queue_head    <= queue_head_next;
      queue_count   <= queue_count_next;
      awaiting_ack  <= awaiting_ack_next;
      inflight_byte <= inflight_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && ok1) queue_mem[pos1] <= LED_CMD;
    if (step && ok2) queue_mem[pos2] <= {{(8 - LED_W){1'b0}}, led_byte};
  end

endmodule

FILE: hdl/keyboard_scancode_decoder_core.sv
// Set-1 keyboard byte decoder with lock LED handling and an 8-byte command queue
// toward the keyboard. One result beat comes out for every input beat, in order:
// a beat is registered on input, then decoded and applied to the modifier, LED and
// queue state as its result lands in an output register, so one beat per clock is
// sustained while out_valid is low or out_ready is high. The input side keeps
// taking beats while a result waits as long as the output register can be freed
// in the same cycle. tx_valid/tx_byte report the byte that must go to the
// keyboard for that beat (a newly dequeued byte, or the byte in flight on
// RESEND); a new queued byte goes out only after the previous one was ACKed.
// boot_leds is written through cfg_wr_en/cfg_wr_data and used by an init beat
// (command = 1); write it only while the block is idle.
module keyboard_scancode_decoder_core
  import ksd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [LED_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             command,
  input  logic [7:0]       scan_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             char_valid,
  output logic [6:0]       char_code,
  output logic             backspace_key,
  output logic             enter_key,
  output logic             tab_key,
  output logic             break_request,
  output logic             f11_key,
  output logic             tx_valid,
  output logic [7:0]       tx_byte,
  output logic [LED_W-1:0] led_state,
  output logic             queue_overflow
);

  logic [LED_W-1:0] boot_leds;

  logic             in_full;
  logic             command_q;
  logic [7:0]       scan_q;
  logic             step;

  logic [1:0]       shift_held, shift_held_next;
  logic             ctrl_held, ctrl_held_next;
  logic [LED_W-1:0] lock_leds, lock_leds_next;

  key_out_t         keys;
  q_ctl_t           q_ctl;
  tx_out_t          tx;

  assign step     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      boot_leds <= '0;
    end else if (cfg_wr_en) begin
      boot_leds <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      command_q <= command;
      scan_q    <= scan_byte;
    end
  end

  ksd_key_decode u_decode (
    .command         (command_q),
    .scan_byte       (scan_q),
    .shift_held      (shift_held),
    .ctrl_held       (ctrl_held),
    .lock_leds       (lock_leds),
    .boot_leds       (boot_leds),
    .keys            (keys),
    .q_ctl           (q_ctl),
    .shift_held_next (shift_held_next),
    .ctrl_held_next  (ctrl_held_next),
    .lock_leds_next  (lock_leds_next)
  );

  ksd_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .q_ctl    (q_ctl),
    .led_byte (lock_leds_next),
    .tx       (tx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= '0;
      ctrl_held  <= 1'b0;
      lock_leds  <= '0;
    end else if (step) begin
      shift_held <= shift_held_next;
      ctrl_held  <= ctrl_held_next;
      lock_leds  <= lock_leds_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      char_valid     <= keys.char_valid;
      char_code      <= keys.char_code;
      backspace_key  <= keys.backspace_key;
      enter_key      <= keys.enter_key;
      tab_key        <= keys.tab_key;
      break_request  <= keys.break_request;
      f11_key        <= keys.f11_key;
      tx_valid       <= tx.tx_valid;
      tx_byte        <= tx.tx_byte;
      led_state      <= lock_leds_next;
      queue_overflow <= tx.overflow;
    end
  end

endmodule

FILE: tb/tb_keyboard_scancode_decoder_core.sv
module tb_keyboard_scancode_decoder_core;
  import ksd_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic             char_valid;
    logic [6:0]       char_code;
    logic             backspace_key;
    logic             enter_key;
    logic             tab_key;
    logic             break_request;
    logic             f11_key;
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic [LED_W-1:0] led_state;
    logic             queue_overflow;
  } key_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [LED_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             command = 1'b0;
  logic [7:0]       scan_byte = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             char_valid;
  logic [6:0]       char_code;
  logic             backspace_key;
  logic             enter_key;
  logic             tab_key;
  logic             break_request;
  logic             f11_key;
  logic             tx_valid;
  logic [7:0]       tx_byte;
  logic [LED_W-1:0] led_state;
  logic             queue_overflow;

  // Shadow of the decoder state
  logic [1:0]       held_shift = 2'b00;
  logic             held_ctrl = 1'b0;
  logic [LED_W-1:0] led_bits = '0;
  logic [LED_W-1:0] boot_led_bits = '0;
  logic             ack_pending = 1'b0;
  logic [7:0]       byte_in_flight = 8'h00;
  logic [7:0]       kb_cmd_q[$];

  key_result_t expected_q[$];
  int          errors = 0;
  int          quiet_cycles = 0;
  int          beats_sent = 0;
  bit          calm = 1'b0;

  keyboard_scancode_decoder_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .scan_byte     (scan_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .char_valid    (char_valid),
    .char_code     (char_code),
    .backspace_key (backspace_key),
    .enter_key     (enter_key),
    .tab_key       (tab_key),
    .break_request (break_request),
    .f11_key       (f11_key),
    .tx_valid      (tx_valid),
    .tx_byte       (tx_byte),
    .led_state     (led_state),
    .queue_overflow(queue_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ASCII for a make code; letters come back upper case
  function automatic logic [7:0] key_ascii(input logic [6:0] code, input bit shifted);
    string row;
    logic [7:0] c;
    c = 8'h00;
    if (code >= 7'h02 && code <= 7'h0D) begin
      row = shifted ? "!\"#$%&'()~=~" : "1234567890-^";
      c = row[code - 7'h02];
    end else if (code >= 7'h10 && code <= 7'h1B) begin
      row = shifted ? "QWERTYUIOP`{" : "QWERTYUIOP@[";
      c = row[code - 7'h10];
    end else if (code >= 7'h1E && code <= 7'h28) begin
      row = shifted ? "ASDFGHJKL+*" : "ASDFGHJKL;:";
      c = row[code - 7'h1E];
    end else if (code >= 7'h2B && code <= 7'h35) begin
      row = shifted ? "}ZXCVBNM<>?" : "]ZXCVBNM,./";
      c = row[code - 7'h2B];
    end else if (code >= 7'h47 && code <= 7'h53) begin
      row = "789-456+1230.";
      c = row[code - 7'h47];
    end else if (code == 7'h37) begin
      c = "*";
    end else if (code == 7'h39) begin
      c = " ";
    end else if (shifted && code == 7'h73) begin
      c = "_";
    end else if (shifted && code == 7'h7D) begin
      c = "|";
    end
    return c;
  endfunction

  function automatic bit push_kb_cmd(input logic [7:0] b);
    if (kb_cmd_q.size() >= CMD_QUEUE_DEPTH) return 1'b0;
    kb_cmd_q.push_back(b);
    return 1'b1;
  endfunction

  // Both LED command bytes are checked for room separately
  function automatic bit queue_led_bytes();
    bit ok_cmd;
    bit ok_val;
    ok_cmd = push_kb_cmd(LED_CMD);
    ok_val = push_kb_cmd({{(8 - LED_W){1'b0}}, led_bits});
    return ok_cmd && ok_val;
  endfunction

  function automatic key_result_t decode_beat(input logic cmd, input logic [7:0] b);
    key_result_t r;
    logic [7:0] ch;
    bit ovf;
    r = '0;
    ch = 8'h00;
    ovf = 1'b0;
    if (cmd) begin
      led_bits = boot_led_bits;
      ovf = !queue_led_bytes();
    end else begin
      if (!b[7]) begin
        ch = key_ascii(b[6:0], held_shift != 2'b00);
        if (ch >= "A" && ch <= "Z" && ((led_bits & LED_CAPS) != 0) == (held_shift != 2'b00))
          ch = ch + 8'h20;
      end
      r.backspace_key = (b == SC_BACKSPACE);
      r.enter_key     = (b == SC_ENTER);
      r.tab_key       = (b == SC_TAB);
      r.f11_key       = (b == SC_F11);
      r.break_request = (b == SC_C) && held_ctrl;
      case (b)
        SC_LSHIFT:     held_shift[0] = 1'b1;
        SC_LSHIFT_BRK: held_shift[0] = 1'b0;
        SC_RSHIFT:     held_shift[1] = 1'b1;
        SC_RSHIFT_BRK: held_shift[1] = 1'b0;
        SC_LCTRL:      held_ctrl = 1'b1;
        SC_LCTRL_BRK:  held_ctrl = 1'b0;
        SC_CAPS, SC_NUM, SC_SCROLL: begin
          led_bits = led_bits ^ ((b == SC_CAPS) ? LED_CAPS : (b == SC_NUM) ? LED_NUM : LED_SCROLL);
          ovf = !queue_led_bytes();
        end
        KB_ACK: ack_pending = 1'b0;
        KB_RESEND: begin
          if (ack_pending) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = byte_in_flight;
          end
        end
        default: ;
      endcase
    end
    if (!ack_pending && kb_cmd_q.size() > 0) begin
      byte_in_flight = kb_cmd_q.pop_front();
      ack_pending = 1'b1;
      r.tx_valid = 1'b1;
      r.tx_byte  = byte_in_flight;
    end
    r.char_valid     = (ch != 8'h00);
    r.char_code      = ch[6:0];
    r.led_state      = led_bits;
    r.queue_overflow = ovf;
    return r;
  endfunction

  task automatic send_beat(input logic cmd, input logic [7:0] b);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    scan_byte <= b;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(decode_beat(cmd, b));
    beats_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_boot_leds(input logic [LED_W-1:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    boot_led_bits = v;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  // ACK and RESEND with nothing in flight
  task automatic test_idle_handshake();
    send_beat(1'b0, KB_RESEND);
    send_beat(1'b0, KB_ACK);
  endtask

  task automatic test_key_extremes();
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b0, 8'h7F);
    send_beat(1'b0, 8'h54);
    send_beat(1'b0, SC_BACKSPACE);
    send_beat(1'b0, SC_ENTER);
    send_beat(1'b0, SC_TAB);
    send_beat(1'b0, SC_F11);
  endtask

  task automatic test_modifiers();
    send_beat(1'b0, SC_LSHIFT);
    send_beat(1'b0, 8'h73);
    send_beat(1'b0, 8'h7D);
    send_beat(1'b0, 8'h1E);
    send_beat(1'b0, SC_LSHIFT_BRK);
    send_beat(1'b0, SC_RSHIFT);
    send_beat(1'b0, 8'h10);
    send_beat(1'b0, SC_RSHIFT_BRK);
    send_beat(1'b0, SC_LCTRL);
    send_beat(1'b0, SC_C);
    send_beat(1'b0, SC_LCTRL_BRK);
  endtask

  task automatic test_lock_leds();
    send_beat(1'b0, SC_CAPS);
    send_beat(1'b0, 8'h1E);
    send_beat(1'b0, KB_RESEND);
    send_beat(1'b0, KB_ACK);
    send_beat(1'b0, KB_ACK);
  endtask

  task automatic test_init_boot();
    set_boot_leds(3'b111);
    send_beat(1'b1, 8'hA5);
    send_beat(1'b0, KB_ACK);
    send_beat(1'b0, KB_ACK);
  endtask

  // No ACKs: the queue fills, then one and then both LED bytes get dropped
  task automatic test_queue_overflow();
    repeat (4) send_beat(1'b0, SC_SCROLL);
    send_beat(1'b1, 8'h00);
    send_beat(1'b0, SC_NUM);
  endtask

  task automatic test_random_traffic(input int n);
    int stop_at;
    int pick;
    int k;
    logic [7:0] code;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        code = 8'($urandom_range(127));
        send_beat(1'b0, code);
        if ($urandom_range(9) < 7) send_beat(1'b0, code | 8'h80);
      end else if (pick < 55) begin
        code = $urandom_range(1) ? SC_LSHIFT : SC_RSHIFT;
        send_beat(1'b0, code);
        k = $urandom_range(4, 1);
        repeat (k) send_beat(1'b0, 8'($urandom_range(127)));
        send_beat(1'b0, code | 8'h80);
      end else if (pick < 62) begin
        send_beat(1'b0, SC_LCTRL);
        send_beat(1'b0, $urandom_range(1) ? SC_C : 8'($urandom_range(127)));
        send_beat(1'b0, SC_LCTRL_BRK);
      end else if (pick < 70) begin
        case ($urandom_range(2))
          0:       code = SC_CAPS;
          1:       code = SC_NUM;
          default: code = SC_SCROLL;
        endcase
        send_beat(1'b0, code);
        if ($urandom_range(3) == 0) send_beat(1'b0, KB_RESEND);
        send_beat(1'b0, KB_ACK);
        send_beat(1'b0, KB_ACK);
      end else if (pick < 80) begin
        send_beat(1'b0, KB_ACK);
      end else if (pick < 85) begin
        send_beat(1'b0, KB_RESEND);
      end else if (pick < 88) begin
        send_beat(1'b1, 8'($urandom_range(255)));
        send_beat(1'b0, KB_ACK);
        send_beat(1'b0, KB_ACK);
      end else begin
        send_beat($urandom_range(9) == 0, 8'($urandom_range(255)));
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin : result_check
    key_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("char_valid", 8'(e.char_valid), 8'(char_valid));
        check_field("char_code", 8'(e.char_code), 8'(char_code));
        check_field("backspace_key", 8'(e.backspace_key), 8'(backspace_key));
        check_field("enter_key", 8'(e.enter_key), 8'(enter_key));
        check_field("tab_key", 8'(e.tab_key), 8'(tab_key));
        check_field("break_request", 8'(e.break_request), 8'(break_request));
        check_field("f11_key", 8'(e.f11_key), 8'(f11_key));
        check_field("tx_valid", 8'(e.tx_valid), 8'(tx_valid));
        check_field("tx_byte", e.tx_byte, tx_byte);
        check_field("led_state", 8'(e.led_state), 8'(led_state));
        check_field("queue_overflow", 8'(e.queue_overflow), 8'(queue_overflow));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb_keyboard_scancode_decoder_core failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_boot_leds(3'b000);
    test_idle_handshake();
    test_key_extremes();
    test_modifiers();
    test_lock_leds();
    test_init_boot();
    test_queue_overflow();

    set_boot_leds(3'($urandom_range(7)));
    test_random_traffic(500);
    // stretch with both sides always ready
    set_boot_leds(3'b111);
    calm = 1'b1;
    test_random_traffic(500);
    set_boot_leds(3'b000);
    calm = 1'b0;
    test_random_traffic(500);
    set_boot_leds(3'($urandom_range(7)));
    test_random_traffic(500);

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("tb_keyboard_scancode_decoder_core passed");
    else
      $display("tb_keyboard_scancode_decoder_core failed");
    $finish;
  end

endmodule

FILE: sim.f
hdl/ksd_pkg.sv
hdl/ksd_key_decode.sv
hdl/ksd_cmd_queue.sv
hdl/keyboard_scancode_decoder_core.sv
tb/tb_keyboard_scancode_decoder_core.sv
